/* hw/rtl/fnq_pkg.sv */
// Shared constants, status codes and helper functions for the frequency to note quantiser.
// No dependencies; every other file imports this package.
`default_nettype none

package fnq_pkg;

    localparam int NUM_OCTAVES = 9;
    localparam int FREQ_W      = 24;
    localparam int REF_W       = 19;
    localparam int LOG_FRAC    = 28;
    localparam int MSB_W       = 5;
    localparam int LOG_W       = MSB_W + LOG_FRAC;
    localparam int X_W         = 40;
    localparam int N_W         = 7;
    localparam int A4_NOTE     = 57;
    localparam int SEMIS       = 12;
    localparam int TOP_OCTAVE  = 8;

    localparam logic [REF_W-1:0] REF_RESET = 19'd450560;

    localparam logic [27:0] LN2_OVER_12_Q32 = 28'd248087040;
    localparam logic [25:0] GAP_UP_Q30      = 26'd63848012;
    localparam logic [25:0] GAP_DOWN_Q30    = 26'd60264498;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_C8    = 2'd2;
    localparam logic [1:0] ST_ABOVE = 2'd3;

    typedef logic [LOG_W-1:0]     t_log;
    typedef logic signed [X_W-1:0] t_x;

    // position of the leading one (0 for a zero word)
    function automatic logic [MSB_W-1:0] lead_one(input logic [FREQ_W-1:0] v);
        logic [MSB_W-1:0] r;
        r = '0;
        for (int k = 0; k < FREQ_W; k++) begin
            if (v[k]) r = MSB_W'(k);
        end
        return r;
    endfunction

    // one log2 fraction bit: square the Q1.31 mantissa, renormalise
    function automatic logic [32:0] sq_step(input logic [31:0] m);
        logic [63:0] p;
        logic [32:0] t;
        p = 64'(m) * 64'(m);
        t = p[63:31];
        return t[32] ? {1'b1, t[32:1]} : {1'b0, t[31:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fnq_ifs.sv */
// Valid/ready channel interfaces for the quantiser: frequency in, note out.
// Depends on fnq_pkg.
`default_nettype none

interface fnq_in_if
    import fnq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency;
    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

interface fnq_out_if
    import fnq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         octave;
    logic [3:0]         semitone;
    logic signed [15:0] tuning_error;
    modport source (output valid, output status, output octave, output semitone,
                    output tuning_error, input ready);
    modport sink   (input valid, input status, input octave, input semitone,
                    input tuning_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fnq_ref_log.sv */
// Iterative log2 of the reference pitch, one fraction bit per cycle.
// Depends on fnq_pkg.
`default_nettype none

module fnq_ref_log
    import fnq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [REF_W-1:0] i_value,
    output logic                  o_busy,
    output t_log                  o_log
);
    logic [MSB_W-1:0]    r_msb;
    logic [LOG_FRAC-1:0] r_frac;
    logic [31:0]         r_m;
    logic [MSB_W-1:0]    r_cnt;
    logic                r_busy;
    logic [FREQ_W-1:0]   v;
    logic [MSB_W-1:0]    msb;
    logic [32:0]         step;

    always_comb begin
        v    = (i_value == '0) ? FREQ_W'(1) : FREQ_W'(i_value);
        msb  = lead_one(v);
        step = sq_step(r_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= MSB_W'(LOG_FRAC);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != MSB_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_msb  <= msb;
            r_m    <= 32'(v) << (5'd31 - msb);
            r_frac <= '0;
        end else if (r_busy) begin
            r_m    <= step[31:0];
            r_frac <= {r_frac[LOG_FRAC-2:0], step[32]};
        end
    end

    assign o_busy = r_busy;
    assign o_log  = {r_msb, r_frac};
endmodule

`default_nettype wire

/* hw/rtl/fnq_front.sv */
// Front end: takes frequency items, pipelined log2 (one squaring per stage), note position x.
// Depends on fnq_pkg.
`default_nettype none

module fnq_front
    import fnq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [FREQ_W-1:0] i_freq,
    input  wire logic              i_ref_ok,
    input  wire t_log              i_ref_log,
    input  wire logic              i_full,
    output logic                   o_valid,
    output t_x                     o_x,
    output logic                   o_zero
);
    localparam int NSQ = LOG_FRAC;
    localparam t_x A4_X = t_x'(A4_NOTE) <<< LOG_FRAC;

    logic                r_v    [0:NSQ+1];
    logic [31:0]         r_m    [0:NSQ];
    logic [LOG_FRAC-1:0] r_fr   [0:NSQ];
    logic [MSB_W-1:0]    r_msb  [0:NSQ];
    logic                r_zero [0:NSQ+1];
    t_x                  r_x;
    logic                en;
    logic [MSB_W-1:0]    msb;
    t_x                  diff;

    assign en      = !r_v[NSQ+1] || !i_full;
    assign o_ready = en && i_ref_ok;
    assign msb     = lead_one(i_freq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSQ + 1; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid && o_ready;
            for (int k = 1; k <= NSQ + 1; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_msb[0]  <= msb;
            r_m[0]    <= 32'(i_freq) << (5'd31 - msb);
            r_fr[0]   <= '0;
            r_zero[0] <= (i_freq == '0);
        end
    end

    for (genvar s = 1; s <= NSQ; s++) begin : g_sq
        logic [32:0] step;
        assign step = sq_step(r_m[s-1]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m[s]    <= step[31:0];
                r_fr[s]   <= {r_fr[s-1][LOG_FRAC-2:0], step[32]};
                r_msb[s]  <= r_msb[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    // x = 57 + 12 * (log2 f - log2 A), Q.28
    assign diff = t_x'({r_msb[NSQ], r_fr[NSQ]}) - t_x'(i_ref_log);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x          <= A4_X + (diff <<< 3) + (diff <<< 2);
            r_zero[NSQ+1] <= r_zero[NSQ];
        end
    end

    assign o_valid = r_v[NSQ+1];
    assign o_x     = r_x;
    assign o_zero  = r_zero[NSQ+1];
endmodule

`default_nettype wire

/* hw/rtl/fnq_fifo.sv */
// Four-entry queue between the front and back ends, carries x and the zero flag.
// Depends on fnq_pkg.
`default_nettype none

module fnq_fifo
    import fnq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_x   i_x,
    input  wire logic i_zero,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_x        o_x,
    output logic      o_zero
);
    logic [X_W:0] r_mem [0:3];
    logic [1:0]   r_wp;
    logic [1:0]   r_rp;
    logic [2:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= {i_zero, i_x};
    end

    assign o_x    = r_mem[r_rp][X_W-1:0];
    assign o_zero = r_mem[r_rp][X_W];
endmodule

`default_nettype wire

/* hw/rtl/fnq_back.sv */
// Back end: classify x, split note into octave/semitone, tuning error series and scaling.
// Depends on fnq_pkg.
`default_nettype none

module fnq_back
    import fnq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_pop,
    input  wire t_x   i_x,
    input  wire logic i_zero,
    input  wire logic i_ready,
    output logic      o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_octave,
    output logic [3:0]  o_semitone,
    output logic signed [15:0] o_err
);
    localparam int NST = 9;
    localparam t_x HALF  = t_x'(1) <<< (LOG_FRAC - 1);
    localparam t_x X_TOP = (t_x'(SEMIS * NUM_OCTAVES) <<< LOG_FRAC) - HALF;
    localparam logic [7:0]  R12 = 8'(((1 << 11) + SEMIS - 1) / SEMIS);
    localparam logic [15:0] R6  = 16'(((1 << 18) + 5) / 6);
    localparam logic [63:0] M_UP   = (64'd1 << 46) / 64'(GAP_UP_Q30);
    localparam logic [63:0] M_DOWN = (64'd1 << 46) / 64'(GAP_DOWN_Q30);

    logic       r_v   [0:NST-1];
    logic [1:0] r_st  [0:NST-2];
    logic       r_neg [0:NST-2];
    logic [3:0] r_oct [1:NST-2];
    logic [3:0] r_sem [2:NST-2];
    logic       en;

    logic [N_W-1:0] r0_n;
    logic [27:0]    r0_a;
    logic [N_W-1:0] r1_n;
    logic [55:0]    r1_up;
    logic [25:0]    r2_u;
    logic [51:0]    r2_uu;
    logic [25:0]    r3_u;
    logic [21:0]    r3_u2;
    logic [47:0]    r3_p3;
    logic [25:0]    r4_u;
    logic [21:0]    r4_u2;
    logic [33:0]    r4_t6;
    logic [41:0]    r5_num;
    logic [41:0]    r6_num;
    logic [17:0]    r6_qe;
    logic [41:0]    r7_num;
    logic [17:0]    r7_qe;
    logic [43:0]    r7_qg;
    logic [1:0]     r8_st;
    logic [3:0]     r8_oct;
    logic [3:0]     r8_sem;
    logic signed [15:0] r8_err;

    // stage 0 combinational
    t_x             xs;
    logic [1:0]     st0;
    logic [N_W-1:0] n0;
    // stage 1..8 combinational
    logic [14:0]    oct_p;
    logic [6:0]     sem_w;
    logic [21:0]    u2s;
    logic [17:0]    t3;
    logic [16:0]    u3;
    logic signed [28:0] p5;
    logic [25:0]    p5c;
    logic [25:0]    gap5;
    logic [46:0]    qprod;
    logic [25:0]    gap7;
    logic [43:0]    rem;
    logic [17:0]    q8;
    logic [15:0]    mag;

    assign en    = !r_v[NST-1] || i_ready;
    assign o_pop = en && i_valid;

    always_comb begin
        xs = i_x + HALF;
        n0 = xs[LOG_FRAC +: N_W];
        if (i_zero || (i_x < -HALF))       st0 = ST_BELOW;
        else if (i_x >= X_TOP)             st0 = ST_ABOVE;
        else if (n0 > N_W'(TOP_OCTAVE * SEMIS)) st0 = ST_C8;
        else                               st0 = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_comb begin
        oct_p = 15'(r0_n) * 15'(R12);
        sem_w = r1_n - 7'(r_oct[1]) * 7'(SEMIS);
        u2s   = r2_uu[51:30];
        t3    = r3_p3[47:30];
        u3    = 17'(r4_t6[33:18]);
        if (r_neg[4]) p5 = 29'(r4_u) - 29'(r4_u2 >> 1) + 29'(u3);
        else          p5 = 29'(r4_u) + 29'(r4_u2 >> 1) + 29'(u3);
        p5c   = (p5 < 0) ? '0 : p5[25:0];
        gap5  = r_neg[4] ? GAP_DOWN_Q30 : GAP_UP_Q30;
        qprod = 47'(r5_num[41:16]) * 47'(r_neg[5] ? M_DOWN[20:0] : M_UP[20:0]);
        gap7  = r_neg[7] ? GAP_DOWN_Q30 : GAP_UP_Q30;
        rem   = 44'(r7_num) - r7_qg;
        q8    = r7_qe + 18'(rem >= 44'(gap7));
        if (r_neg[7]) mag = (q8 > 18'd32768) ? 16'h8000 : q8[15:0];
        else          mag = (q8 > 18'd32767) ? 16'h7FFF : q8[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 0: classify, note index, |d|
            r_st[0]  <= st0;
            r0_n     <= n0;
            r_neg[0] <= !xs[LOG_FRAC-1];
            r0_a     <= xs[LOG_FRAC-1] ? 28'(xs[LOG_FRAC-2:0])
                                       : 28'(1 << (LOG_FRAC - 1)) - 28'(xs[LOG_FRAC-2:0]);
            // stage 1: octave, u product
            r_st[1]  <= r_st[0];
            r_neg[1] <= r_neg[0];
            r_oct[1] <= oct_p[14:11];
            r1_n     <= r0_n;
            r1_up    <= 56'(r0_a) * 56'(LN2_OVER_12_Q32);
            // stage 2: semitone, u^2
            r_st[2]  <= r_st[1];
            r_neg[2] <= r_neg[1];
            r_oct[2] <= r_oct[1];
            r_sem[2] <= sem_w[3:0];
            r2_u     <= r1_up[55:30];
            r2_uu    <= 52'(r1_up[55:30]) * 52'(r1_up[55:30]);
            // stage 3: u^3
            r_st[3]  <= r_st[2];
            r_neg[3] <= r_neg[2];
            r_oct[3] <= r_oct[2];
            r_sem[3] <= r_sem[2];
            r3_u     <= r2_u;
            r3_u2    <= u2s;
            r3_p3    <= 48'(u2s) * 48'(r2_u);
            // stage 4: divide by six
            r_st[4]  <= r_st[3];
            r_neg[4] <= r_neg[3];
            r_oct[4] <= r_oct[3];
            r_sem[4] <= r_sem[3];
            r4_u     <= r3_u;
            r4_u2    <= r3_u2;
            r4_t6    <= 34'(t3) * 34'(R6);
            // stage 5: series sum, numerator
            r_st[5]  <= r_st[4];
            r_neg[5] <= r_neg[4];
            r_oct[5] <= r_oct[4];
            r_sem[5] <= r_sem[4];
            r5_num   <= (42'(p5c) << 15) + 42'(gap5 >> 1);
            // stage 6: quotient estimate
            r_st[6]  <= r_st[5];
            r_neg[6] <= r_neg[5];
            r_oct[6] <= r_oct[5];
            r_sem[6] <= r_sem[5];
            r6_num   <= r5_num;
            r6_qe    <= 18'(qprod[46:30]);
            // stage 7: back-multiply
            r_st[7]  <= r_st[6];
            r_neg[7] <= r_neg[6];
            r_oct[7] <= r_oct[6];
            r_sem[7] <= r_sem[6];
            r7_num   <= r6_num;
            r7_qe    <= r6_qe;
            r7_qg    <= 44'(r6_qe) * 44'(r_neg[6] ? GAP_DOWN_Q30 : GAP_UP_Q30);
            // stage 8: correct, saturate, result register
            r8_st    <= r_st[7];
            r8_oct   <= (r_st[7] == ST_OK || r_st[7] == ST_C8) ? r_oct[7] : 4'd0;
            r8_sem   <= (r_st[7] == ST_OK) ? r_sem[7] : 4'd0;
            r8_err   <= (r_st[7] != ST_OK) ? 16'sd0
                      : r_neg[7] ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_valid    = r_v[NST-1];
    assign o_status   = r8_st;
    assign o_octave   = r8_oct;
    assign o_semitone = r8_sem;
    assign o_err      = r8_err;
endmodule

`default_nettype wire

/* hw/rtl/frequency_to_note_quantizer.sv */
// Top level of the frequency to nearest equal-tempered note quantiser.
// Depends on fnq_pkg, fnq_ifs, fnq_ref_log, fnq_front, fnq_fifo, fnq_back.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    frequency  (u Q14.10 Hz, 24 b)
//  o_out    out  valid/ready    status 2b, octave 4b, semitone 4b, tuning_error s16 Q1.15
//  i_cfg    in   i_cfg_we       i_cfg_data = reference A4 (u Q9.10 Hz, 19 b)
//
// One item per cycle while the output takes items and no reference log2 is being worked out;
// items pass the log2 pipeline (one squaring multiplier per fraction bit), the queue and the back end.
// After reset and after each reference write the reference log2 is worked out by a separate
// squaring unit, one fraction bit at a time; items are refused (ready low) until it is done.
// Synchronous active-low reset clears only control state. A stalled output fills the
// back end, then the four-item queue, then the front pipeline, each stage holding its item.
`default_nettype none

module frequency_to_note_quantizer
    import fnq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    fnq_in_if.sink                i_in,
    fnq_out_if.source             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [REF_W-1:0] i_cfg_data
);
    logic [REF_W-1:0] r_ref;
    logic             r_load;   // reference log2 needs a fresh run
    logic             ref_busy;
    t_log             ref_log;

    logic front_valid;
    t_x   front_x;
    logic front_zero;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_x   q_x;
    logic q_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= REF_RESET;
            r_load <= 1'b1;
        end else begin
            if (i_cfg_we) r_ref <= i_cfg_data;
            r_load <= i_cfg_we;
        end
    end

    fnq_ref_log u_ref_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_load),
        .i_value (r_ref),
        .o_busy  (ref_busy),
        .o_log   (ref_log)
    );

    fnq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_freq    (i_in.frequency),
        .i_ref_ok  (!ref_busy && !r_load),
        .i_ref_log (ref_log),
        .i_full    (q_full),
        .o_valid   (front_valid),
        .o_x       (front_x),
        .o_zero    (front_zero)
    );

    fnq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_x     (front_x),
        .i_zero  (front_zero),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_x     (q_x),
        .o_zero  (q_zero)
    );

    fnq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_x        (q_x),
        .i_zero     (q_zero),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_status   (o_out.status),
        .o_octave   (o_out.octave),
        .o_semitone (o_out.semitone),
        .o_err      (o_out.tuning_error)
    );

    // no item enters while the reference log2 is stale
    a_ref_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ref_busy || r_load) |-> !i_in.ready) else $error("item taken during ref log2");

    // a load always starts the reference unit
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |=> ref_busy) else $error("reference unit did not start");

    // fields without meaning read zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
        (o_out.tuning_error == 16'sd0 && o_out.semitone == 4'd0))
        else $error("non-ok item carries note data");

    // ok notes stay in the scale
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK) |->
        (o_out.octave <= 4'(TOP_OCTAVE) && o_out.semitone <= 4'(SEMIS - 1)))
        else $error("note out of range");
endmodule

`default_nettype wire

/* dv/fnq_note_checker.sv */
// Note checker for the frequency to note quantiser: predicts each note from the frequency
// and reference A4, compares with the output channel. Depends on fnq_pkg and fnq_ifs.
`timescale 1ns / 100ps

module fnq_note_checker
    import fnq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    fnq_in_if                     i_in,
    fnq_out_if                    i_out,
    input  wire logic             i_cfg_we,
    input  wire logic [REF_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_notes_seen
);

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         octave;
        logic [3:0]         semitone;
        logic signed [15:0] tuning_error;
    } t_note;

    localparam longint HALF_Q28 = 64'sd1 << (LOG_FRAC - 1);
    localparam longint ONE_Q28  = 64'sd1 << LOG_FRAC;

    logic [REF_W-1:0] ref_a4;
    t_note            notes_due[$];

    // log2 in Q.28: leading one gives the integer, squaring gives the fraction bits
    function automatic longint log2_q28(input longint unsigned v);
        int              msb;
        longint unsigned m;
        longint          frac;
        msb  = 0;
        frac = 0;
        for (int k = 0; k < 32; k++) if (v[k]) msb = k;
        m = v << (31 - msb);
        for (int k = 0; k < LOG_FRAC; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(msb) << LOG_FRAC) | frac;
    endfunction

    // offset as a fraction of the gap to the neighbour note, Q1.15
    function automatic logic signed [15:0] detune(input longint d);
        longint a, u, u2, u3, p, q;
        a  = (d < 0) ? -d : d;
        u  = (a * longint'(LN2_OVER_12_Q32)) >>> 30;
        u2 = (u * u) >>> 30;
        u3 = ((u2 * u) >>> 30) / 6;
        if (d < 0) begin
            p = u - u2 / 2 + u3;
            if (p < 0) p = 0;
            q = ((p <<< 15) + longint'(GAP_DOWN_Q30) / 2) / longint'(GAP_DOWN_Q30);
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        p = u + u2 / 2 + u3;
        q = ((p <<< 15) + longint'(GAP_UP_Q30) / 2) / longint'(GAP_UP_Q30);
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function automatic t_note nearest_note(input logic [FREQ_W-1:0] f,
                                           input logic [REF_W-1:0] a4);
        t_note  r;
        longint x, n, a;
        r = '0;
        a = (a4 == 0) ? 1 : longint'(a4);
        if (f == 0) begin
            r.status = ST_BELOW;
        end else begin
            x = A4_NOTE * ONE_Q28 + SEMIS * (log2_q28(longint'(f)) - log2_q28(a));
            if (x < -HALF_Q28) begin
                r.status = ST_BELOW;
            end else if (x >= SEMIS * NUM_OCTAVES * ONE_Q28 - HALF_Q28) begin
                r.status = ST_ABOVE;
            end else begin
                n = (x + HALF_Q28) >>> LOG_FRAC;
                r.octave = 4'(n / SEMIS);
                if (n > TOP_OCTAVE * SEMIS) begin
                    r.status = ST_C8;
                end else begin
                    r.semitone     = 4'(n % SEMIS);
                    r.tuning_error = detune(x - n * ONE_Q28);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_note want;
        if (!i_rst_n) begin
            ref_a4 <= REF_RESET;
            notes_due.delete();
            o_fail_count <= 0;
            o_notes_seen <= 0;
        end else begin
            if (i_cfg_we) ref_a4 <= i_cfg_data;
            if (i_in.valid && i_in.ready) notes_due.push_back(nearest_note(i_in.frequency, ref_a4));
            if (i_out.valid && i_out.ready) begin
                o_notes_seen <= o_notes_seen + 1;
                if (notes_due.size() == 0) begin
                    $error("note with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = notes_due.pop_front();
                    if (want.status !== i_out.status ||
                        want.octave !== i_out.octave ||
                        want.semitone !== i_out.semitone ||
                        want.tuning_error !== i_out.tuning_error)
                        o_fail_count <= o_fail_count + 1;
                    if (want.status !== i_out.status)
                        $error("status: expected %0d, got %0d", want.status, i_out.status);
                    if (want.octave !== i_out.octave)
                        $error("octave: expected %0d, got %0d", want.octave, i_out.octave);
                    if (want.semitone !== i_out.semitone)
                        $error("semitone: expected %0d, got %0d", want.semitone, i_out.semitone);
                    if (want.tuning_error !== i_out.tuning_error)
                        $error("tuning_error: expected %0d, got %0d",
                               want.tuning_error, i_out.tuning_error);
                end
            end
        end
    end

    assign o_pending = notes_due.size();

endmodule

/* dv/tb_frequency_to_note_quantizer.sv */
// Testbench top for the frequency to note quantiser: clock, reset, frequency stimulus,
// reference A4 writes, output back-pressure and verdict. Depends on fnq_pkg, fnq_ifs, checker.
`timescale 1ns / 100ps

module tb_frequency_to_note_quantizer;
    import fnq_pkg::*;

    localparam int N_RANDOM   = 2000;
    localparam int DRAIN_WAIT = 80;       // well beyond the pipeline depth
    localparam int CYCLE_CAP  = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [REF_W-1:0] i_cfg_data = '0;
    int               fail_count, pending, notes_seen;
    int               cycle_no = 0;
    int               sent = 0;
    bit               steady = 1'b0;      // no idling on either side while set

    fnq_in_if  in_ch();
    fnq_out_if out_ch();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.frequency = '0;
        out_ch.ready = 1'b0;
    end

    frequency_to_note_quantizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    fnq_note_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_notes_seen(notes_seen)
    );

    always #6 i_clk = ~i_clk;

    // cycle guard: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_no);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sink stalls on about 22 percent of cycles, never while steady
    always @(posedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= 22);
    end

    // one item: optional idle gap, then hold valid until accepted
    task automatic send_freq(input logic [FREQ_W-1:0] f);
        while (!steady && $urandom_range(99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.frequency <= f;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // reference writes only with the pipe empty; the block then relearns log2(A4)
    task automatic set_reference(input logic [REF_W-1:0] a4);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a4;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly musical range around A4, some anywhere in the 24-bit field
    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            0:       return FREQ_W'($urandom);
            1:       return FREQ_W'($urandom_range(20000));
            2:       return FREQ_W'($urandom_range(16777215, 8000000));
            default: return FREQ_W'($urandom_range(8000000, 16000));
        endcase
    endfunction

    logic [REF_W-1:0] refs[6] = '{19'd409600, 19'd491520, 19'd450560, 19'd0,
                                   19'h7FFFF, 19'd430080};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, each status, halfway and exact notes at 440 Hz
        send_freq(24'd0);
        send_freq(24'd1);
        send_freq(24'hFFFFFF);
        send_freq(24'h800000);
        send_freq(24'h555555);
        send_freq(24'hAAAAAA);
        send_freq(24'd450560);             // A4 exactly
        send_freq(24'd16736);              // near C0
        send_freq(24'd16000);              // just below octave 0
        send_freq(24'd4306542);            // near C8
        send_freq(24'd4600000);            // above C8
        send_freq(24'd8600000);            // above octave 8
        send_freq(24'd9000000);            // above octave 8
        send_freq(24'd463748);             // quarter tone above A4
        send_freq(24'd437766);             // quarter tone below A4
        send_freq(24'd451000);
        send_freq(24'd450000);

        // random, walking through the reference settings including zero and all ones
        for (int r = 0; r < 6; r++) begin
            set_reference(refs[r]);
            steady = (r == 2);
            for (int i = 0; i < N_RANDOM / 6; i++) send_freq(pick_freq());
            steady = 1'b0;
        end
        set_reference(REF_RESET);
        for (int i = 0; i < 30; i++) send_freq(pick_freq());

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d frequencies, checked %0d notes over six A4 references.",
                 sent, notes_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
